/* hw/rtl/scfp_pkg.sv */
// ----------------------------------------------------------------------------
// scfp_pkg: shared types and constants of the serial command frame parser
// Frame phases, result kinds, register indexes and the register file layout.
// ----------------------------------------------------------------------------
package scfp_pkg;

  // Default frame lengths in bytes, prefix included
  localparam int unsigned CommandFrameBytesDef   = 2;
  localparam int unsigned ParameterFrameBytesDef = 3;

  // Byte counter width, sized for the longest frame (7 bytes)
  localparam int unsigned CountW = 3;

  // Word width on the receive side
  localparam int unsigned ByteW = 8;

  // Frame phase of the parser
  typedef enum logic [1:0] {
    PhIdle      = 2'd0,
    PhCommand   = 2'd1,
    PhParameter = 2'd2
  } phase_e;

  // Result kind codes
  typedef enum logic [2:0] {
    KindConnect    = 3'd0,
    KindDataStart  = 3'd1,
    KindDataStop   = 3'd2,
    KindMotorStart = 3'd3,
    KindMotorStop  = 3'd4,
    KindUnknown    = 3'd5
  } kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    RegCommandPrefix   = 3'd0,
    RegParameterPrefix = 3'd1,
    RegConnectCode     = 3'd2,
    RegDataStartCode   = 3'd3,
    RegDataStopCode    = 3'd4,
    RegMotorStartCode  = 3'd5,
    RegMotorStopCode   = 3'd6
  } reg_idx_e;

  // Register reset values
  localparam logic [ByteW-1:0] CommandPrefixRst   = 8'd0;
  localparam logic [ByteW-1:0] ParameterPrefixRst = 8'd1;
  localparam logic [ByteW-1:0] ConnectCodeRst     = 8'd0;
  localparam logic [ByteW-1:0] DataStartCodeRst   = 8'd1;
  localparam logic [ByteW-1:0] DataStopCodeRst    = 8'd2;
  localparam logic [ByteW-1:0] MotorStartCodeRst  = 8'd0;
  localparam logic [ByteW-1:0] MotorStopCodeRst   = 8'd1;

  // Register file contents as seen by the parser
  typedef struct packed {
    logic [ByteW-1:0] cmd_open_byte;
    logic [ByteW-1:0] par_open_byte;
    logic [ByteW-1:0] connect_code;
    logic [ByteW-1:0] data_start_code;
    logic [ByteW-1:0] data_stop_code;
    logic [ByteW-1:0] motor_start_code;
    logic [ByteW-1:0] motor_stop_code;
  } cfg_t;

  // One parsed frame
  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] power;
  } result_t;

endpackage

/* hw/rtl/serial_command_frame_parser_core.sv */
// A word accepted into the input register is stepped through the parser into the output register.
// Throughput: one word per cycle; the parser steps the input register once per cycle
// whenever the output register is free or being drained.
// Back-pressure on the output stalls the input register, then the input side.
// Reset: asynchronous, active low; parser idle, registers at their defaults.
// ----------------------------------------------------------------------------
// serial_command_frame_parser_core: serial command frame parser
// Input register, frame tracker and output register for received bytes,
// plus the configuration register file.
// ----------------------------------------------------------------------------
module serial_command_frame_parser_core import scfp_pkg::*; #(
  parameter int unsigned COMMAND_FRAME_BYTES   = CommandFrameBytesDef,
  parameter int unsigned PARAMETER_FRAME_BYTES = ParameterFrameBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Receive channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] rx_byte_i,
  // Result channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       command_kind_o,
  output logic [ByteW-1:0] motor_power_o,
  // Configuration write channel
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [ByteW-1:0] cfg_data_i
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  result_t          out_res_q;

  logic    out_free;
  logic    step;
  logic    res_valid;
  result_t res;
  cfg_t    cfg;

  // Register file
  assign cfg_ready_o = 1'b1;

  scfp_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Step the parser when a word is held and the output slot can take a result
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  scfp_frame_fsm #(
    .COMMAND_FRAME_BYTES   (COMMAND_FRAME_BYTES),
    .PARAMETER_FRAME_BYTES (PARAMETER_FRAME_BYTES)
  ) u_frame_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign command_kind_o = out_res_q.kind;
  assign motor_power_o  = out_res_q.power;

endmodule

/* hw/rtl/scfp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// scfp_cfg_regs: configuration register file
// Holds the prefix and code byte values; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module scfp_cfg_regs import scfp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [2:0]       wr_index_i,
  input  logic [ByteW-1:0] wr_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (reg_idx_e'(wr_index_i))
        RegCommandPrefix:   cfg_d.cmd_open_byte    = wr_data_i;
        RegParameterPrefix: cfg_d.par_open_byte    = wr_data_i;
        RegConnectCode:     cfg_d.connect_code     = wr_data_i;
        RegDataStartCode:   cfg_d.data_start_code  = wr_data_i;
        RegDataStopCode:    cfg_d.data_stop_code   = wr_data_i;
        RegMotorStartCode:  cfg_d.motor_start_code = wr_data_i;
        RegMotorStopCode:   cfg_d.motor_stop_code  = wr_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cmd_open_byte    <= CommandPrefixRst;
      cfg_q.par_open_byte    <= ParameterPrefixRst;
      cfg_q.connect_code     <= ConnectCodeRst;
      cfg_q.data_start_code  <= DataStartCodeRst;
      cfg_q.data_stop_code   <= DataStopCodeRst;
      cfg_q.motor_start_code <= MotorStartCodeRst;
      cfg_q.motor_stop_code  <= MotorStopCodeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/scfp_frame_fsm.sv */
// ----------------------------------------------------------------------------
// scfp_frame_fsm: frame tracking and classification
// Tracks the open frame, captures code and power bytes and classifies the
// frame on its last byte.
// ----------------------------------------------------------------------------
module scfp_frame_fsm import scfp_pkg::*; #(
  parameter int unsigned COMMAND_FRAME_BYTES   = CommandFrameBytesDef,
  parameter int unsigned PARAMETER_FRAME_BYTES = ParameterFrameBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  cfg_t             cfg_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  localparam logic [CountW-1:0] CmdLen   = CountW'(COMMAND_FRAME_BYTES);
  localparam logic [CountW-1:0] ParLen   = CountW'(PARAMETER_FRAME_BYTES);
  localparam logic [CountW-1:0] CodePos  = CountW'(2);
  localparam logic [CountW-1:0] PowerPos = CountW'(3);

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;
  logic [ByteW-1:0]  code_q, code_d;
  logic [ByteW-1:0]  power_q, power_d;

  logic [CountW-1:0] count_inc;
  logic [ByteW-1:0]  code_now;
  logic [ByteW-1:0]  power_now;

  // Position of this word in the open frame and the bytes it lands in
  assign count_inc = count_q + CountW'(1);
  assign code_now  = (count_inc == CodePos) ? byte_i : code_q;
  assign power_now = (phase_q == PhParameter && count_inc == PowerPos) ? byte_i : power_q;

  // Next state and frame result
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    code_d      = code_q;
    power_d     = power_q;
    res_valid_o = 1'b0;
    res_o.kind  = KindUnknown;
    res_o.power = '0;

    case (phase_q)
      PhCommand: begin
        if (count_inc >= CmdLen) begin
          res_valid_o = 1'b1;
          if (code_now == cfg_i.connect_code) begin
            res_o.kind = KindConnect;
          end else if (code_now == cfg_i.data_start_code) begin
            res_o.kind = KindDataStart;
          end else if (code_now == cfg_i.data_stop_code) begin
            res_o.kind = KindDataStop;
          end else begin
            res_o.kind = KindUnknown;
          end
          phase_d = PhIdle;
          count_d = '0;
          code_d  = '0;
          power_d = '0;
        end else begin
          count_d = count_inc;
          code_d  = code_now;
        end
      end
      PhParameter: begin
        if (count_inc >= ParLen) begin
          res_valid_o = 1'b1;
          if (code_now == cfg_i.motor_start_code) begin
            res_o.kind  = KindMotorStart;
            res_o.power = power_now;
          end else if (code_now == cfg_i.motor_stop_code) begin
            res_o.kind = KindMotorStop;
          end else begin
            res_o.kind = KindUnknown;
          end
          phase_d = PhIdle;
          count_d = '0;
          code_d  = '0;
          power_d = '0;
        end else begin
          count_d = count_inc;
          code_d  = code_now;
          power_d = power_now;
        end
      end
      default: begin
        // Idle: open a frame on a prefix, command prefix first; drop the rest
        code_d  = '0;
        power_d = '0;
        if (byte_i == cfg_i.cmd_open_byte) begin
          phase_d = PhCommand;
          count_d = CountW'(1);
        end else if (byte_i == cfg_i.par_open_byte) begin
          phase_d = PhParameter;
          count_d = CountW'(1);
        end else begin
          phase_d = PhIdle;
          count_d = '0;
        end
      end
    endcase
  end

  // Advance the frame state on each processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      count_q <= '0;
      code_q  <= '0;
      power_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      code_q  <= code_d;
      power_q <= power_d;
    end
  end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench of the serial command frame parser core
// Feeds received bytes and register writes through the valid/ready channels,
// predicts every parsed frame in a local tracker and checks each result word
// field by field, with random gaps on the byte side and random output stalls.
// ----------------------------------------------------------------------------
module tb;
  import scfp_pkg::*;

  localparam int unsigned CmdLen      = 2;
  localparam int unsigned ParLen      = 3;
  localparam int unsigned RandomBytes = 1750;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned MaxReports  = 100;
  // Byte positions within a frame, prefix counted as the first
  localparam logic [CountW-1:0] CodePos  = 3'd2;
  localparam logic [CountW-1:0] PowerPos = 3'd3;
  // Index past the register file; writes to it must be dropped
  localparam logic [2:0] RegBeyond = 3'd7;

  typedef enum logic [1:0] {
    FeedByte,
    FeedReg,
    FeedDrain
  } feed_e;

  typedef struct {
    feed_e            op;
    logic [ByteW-1:0] data;
    logic [2:0]       idx;
    int unsigned      gap;
  } feed_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] rx_byte_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [2:0]       command_kind_o;
  logic [ByteW-1:0] motor_power_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [2:0]       cfg_index_i = '0;
  logic [ByteW-1:0] cfg_data_i  = '0;

  feed_t       feed_q[$];
  result_t     frames_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // Frame tracker and register file of the predictor
  phase_e            trk_phase;
  logic [CountW-1:0] trk_count;
  logic [ByteW-1:0]  trk_code;
  logic [ByteW-1:0]  trk_power;
  cfg_t              reg_file;

  // Generator side view of the registers, used to build well-formed frames
  cfg_t gen_cfg;
  bit   feed_calm;

  // Driver state
  feed_t       cur;
  bit          holding;
  bit          rx_up;
  bit          cfg_up;
  int unsigned wait_left;
  int unsigned settle;

  // Monitor state
  int unsigned stall;
  int unsigned seen;
  bit          calm_out;

  serial_command_frame_parser_core #(
    .COMMAND_FRAME_BYTES  (CmdLen),
    .PARAMETER_FRAME_BYTES(ParLen)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .command_kind_o(command_kind_o),
    .motor_power_o (motor_power_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  task automatic report(input string what);
    errors++;
    if (errors <= MaxReports) $display("mismatch: %s", what);
  endtask

  function automatic int unsigned draw_wait(input bit calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // Apply one register write; indexes past the file leave it unchanged
  function automatic cfg_t apply_reg(input cfg_t c, input logic [2:0] idx,
                                     input logic [ByteW-1:0] d);
    cfg_t n;
    n = c;
    case (idx)
      RegCommandPrefix:   n.cmd_open_byte    = d;
      RegParameterPrefix: n.par_open_byte    = d;
      RegConnectCode:     n.connect_code     = d;
      RegDataStartCode:   n.data_start_code  = d;
      RegDataStopCode:    n.data_stop_code   = d;
      RegMotorStartCode:  n.motor_start_code = d;
      RegMotorStopCode:   n.motor_stop_code  = d;
      default: ;
    endcase
    return n;
  endfunction

  function automatic void close_frame();
    trk_phase = PhIdle;
    trk_count = '0;
    trk_code  = '0;
    trk_power = '0;
  endfunction

  // Advance the frame tracker by one accepted byte and queue the parsed frame
  task automatic parse_rx_byte(input logic [ByteW-1:0] b);
    result_t got;
    // Idle: open a frame on a prefix, command prefix first; drop anything else
    if (trk_phase != PhCommand && trk_phase != PhParameter) begin
      if (b == reg_file.cmd_open_byte) begin
        trk_phase = PhCommand;
        trk_count = 3'd1;
      end else if (b == reg_file.par_open_byte) begin
        trk_phase = PhParameter;
        trk_count = 3'd1;
      end else begin
        close_frame();
      end
      return;
    end
    trk_count = trk_count + 3'd1;
    if (trk_count == CodePos) trk_code = b;
    if (trk_phase == PhParameter && trk_count == PowerPos) trk_power = b;
    got.power = '0;
    if (trk_phase == PhCommand) begin
      if (trk_count < CmdLen) return;
      if (trk_code == reg_file.connect_code) got.kind = KindConnect;
      else if (trk_code == reg_file.data_start_code) got.kind = KindDataStart;
      else if (trk_code == reg_file.data_stop_code) got.kind = KindDataStop;
      else got.kind = KindUnknown;
    end else begin
      if (trk_count < ParLen) return;
      if (trk_code == reg_file.motor_start_code) begin
        got.kind  = KindMotorStart;
        got.power = trk_power;
      end else if (trk_code == reg_file.motor_stop_code) begin
        got.kind = KindMotorStop;
      end else begin
        got.kind = KindUnknown;
      end
    end
    frames_q.push_back(got);
    close_frame();
  endtask

  function automatic void push_byte(input logic [ByteW-1:0] b);
    feed_t f;
    f.op   = FeedByte;
    f.data = b;
    f.idx  = '0;
    f.gap  = draw_wait(feed_calm);
    feed_q.push_back(f);
  endfunction

  function automatic void push_reg(input logic [2:0] idx, input logic [ByteW-1:0] d);
    feed_t f;
    f.op   = FeedReg;
    f.data = d;
    f.idx  = idx;
    f.gap  = draw_wait(feed_calm);
    feed_q.push_back(f);
    gen_cfg = apply_reg(gen_cfg, idx, d);
  endfunction

  function automatic void push_drain();
    feed_t f;
    f.op   = FeedDrain;
    f.data = '0;
    f.idx  = '0;
    f.gap  = 0;
    feed_q.push_back(f);
  endfunction

  function automatic logic [ByteW-1:0] pick_reg_value(input int unsigned style);
    case (style)
      1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2:       return 8'($urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Timeout guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("[serial_command_frame_parser_core] ERROR");
      $finish;
    end
  end

  // Driver: present words from the feed queue, predict on each accepted byte
  always @(posedge clk_i or negedge rst_ni) begin : drive
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      rx_byte_i   <= '0;
      cfg_valid_i <= 1'b0;
      cfg_index_i <= '0;
      cfg_data_i  <= '0;
      holding     = 1'b0;
      rx_up       = 1'b0;
      cfg_up      = 1'b0;
      wait_left   = 0;
      settle      = 0;
      reg_file.cmd_open_byte    = CommandPrefixRst;
      reg_file.par_open_byte    = ParameterPrefixRst;
      reg_file.connect_code     = ConnectCodeRst;
      reg_file.data_start_code  = DataStartCodeRst;
      reg_file.data_stop_code   = DataStopCodeRst;
      reg_file.motor_start_code = MotorStartCodeRst;
      reg_file.motor_stop_code  = MotorStopCodeRst;
      close_frame();
    end else begin
      if (in_valid_i && in_ready_o) begin
        parse_rx_byte(rx_byte_i);
        rx_up   = 1'b0;
        holding = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        reg_file = apply_reg(reg_file, cfg_index_i, cfg_data_i);
        cfg_up   = 1'b0;
        holding  = 1'b0;
      end
      // Fetch the next word and load its gap
      if (!holding && feed_q.size() != 0) begin
        cur       = feed_q.pop_front();
        holding   = 1'b1;
        wait_left = cur.gap;
        settle    = 0;
      end
      // Hold register writes and drains until the parser has gone quiet
      if (holding && !rx_up && !cfg_up) begin
        if (wait_left != 0) wait_left--;
        else if (cur.op == FeedByte) rx_up = 1'b1;
        else if (frames_q.size() != 0 || out_valid_o) settle = 0;
        else if (settle < SettleCycles) settle++;
        else if (cur.op == FeedReg) cfg_up = 1'b1;
        else holding = 1'b0;
      end
      in_valid_i  <= rx_up;
      cfg_valid_i <= cfg_up;
      if (rx_up) rx_byte_i <= cur.data;
      if (cfg_up) begin
        cfg_index_i <= cur.idx;
        cfg_data_i  <= cur.data;
      end
    end
  end

  // Monitor: check each result word against the oldest predicted frame
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall    = 0;
      seen     = 0;
      calm_out = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (frames_q.size() == 0) begin
          report($sformatf("result kind %0d power %0d with no frame pending",
                           command_kind_o, motor_power_o));
        end else begin
          want = frames_q.pop_front();
          if (command_kind_o !== want.kind)
            report($sformatf("command kind %0d, expected %0d (%s)",
                             command_kind_o, want.kind, want.kind.name()));
          if (motor_power_o !== want.power)
            report($sformatf("motor power %0d, expected %0d", motor_power_o, want.power));
        end
        seen++;
        if (seen % 50 == 0) calm_out = !calm_out;
        stall = draw_wait(calm_out);
      end else if (stall != 0) begin
        stall--;
      end
      out_ready_i <= (stall == 0);
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned frame_bytes;
    int unsigned n;
    int unsigned roll;
    int unsigned style;
    logic [ByteW-1:0] code;
    reg_idx_e ri;

    gen_cfg.cmd_open_byte    = CommandPrefixRst;
    gen_cfg.par_open_byte    = ParameterPrefixRst;
    gen_cfg.connect_code     = ConnectCodeRst;
    gen_cfg.data_start_code  = DataStartCodeRst;
    gen_cfg.data_stop_code   = DataStopCodeRst;
    gen_cfg.motor_start_code = MotorStartCodeRst;
    gen_cfg.motor_stop_code  = MotorStopCodeRst;
    feed_calm = 1'b0;

    // Directed: every command kind at reset values, noise, extreme bytes
    push_byte(8'h00); push_byte(8'h00);
    push_byte(8'h00); push_byte(8'h01);
    push_byte(8'h00); push_byte(8'h02);
    push_byte(8'h00); push_byte(8'hFF);
    push_byte(8'hFF); push_byte(8'h55);
    push_byte(8'h01); push_byte(8'h00); push_byte(8'hFF);
    push_byte(8'h01); push_byte(8'h01); push_byte(8'h80);
    push_byte(8'h01); push_byte(8'h7F); push_byte(8'h00);
    // prefix value as the power byte
    push_byte(8'h01); push_byte(8'h00); push_byte(8'h01);

    // Directed: shared prefix, overlapping codes, out-of-range index
    push_reg(RegBeyond, 8'h5A);
    push_reg(RegCommandPrefix, 8'hAA);
    push_reg(RegParameterPrefix, 8'hAA);
    push_reg(RegConnectCode, 8'h33);
    push_reg(RegDataStartCode, 8'h33);
    push_reg(RegDataStopCode, 8'h33);
    push_reg(RegMotorStartCode, 8'h44);
    push_reg(RegMotorStopCode, 8'h44);
    push_byte(8'hAA); push_byte(8'h33);
    push_byte(8'hAA); push_byte(8'h44);
    push_byte(8'hAA); push_byte(8'hAA);

    // Random phases: new register set, then mostly well-formed frames
    frame_bytes = 0;
    while (frame_bytes < RandomBytes) begin
      feed_calm = ($urandom_range(0, 3) == 0);
      style = $urandom_range(0, 3);
      ri = ri.first();
      do begin
        push_reg(ri, pick_reg_value(style));
        ri = ri.next();
      end while (ri != ri.first());
      if ($urandom_range(0, 3) == 0) push_reg(RegBeyond, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) push_reg(RegParameterPrefix, gen_cfg.cmd_open_byte);

      n = $urandom_range(40, 200);
      for (int unsigned k = 0; k < n && frame_bytes < RandomBytes; k++) begin
        roll = $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) push_drain();
        if (roll < 4) begin
          case ($urandom_range(0, 3))
            0:       code = gen_cfg.connect_code;
            1:       code = gen_cfg.data_start_code;
            2:       code = gen_cfg.data_stop_code;
            default: code = 8'($urandom_range(0, 255));
          endcase
          push_byte(gen_cfg.cmd_open_byte);
          push_byte(code);
          for (int unsigned j = 2; j < CmdLen; j++) push_byte(8'($urandom_range(0, 255)));
          frame_bytes += CmdLen;
        end else if (roll < 8) begin
          case ($urandom_range(0, 2))
            0:       code = gen_cfg.motor_start_code;
            1:       code = gen_cfg.motor_stop_code;
            default: code = 8'($urandom_range(0, 255));
          endcase
          push_byte(gen_cfg.par_open_byte);
          push_byte(code);
          case ($urandom_range(0, 5))
            0:       push_byte(8'h00);
            1:       push_byte(8'hFF);
            default: push_byte(8'($urandom_range(0, 255)));
          endcase
          for (int unsigned j = 3; j < ParLen; j++) push_byte(8'($urandom_range(0, 255)));
          frame_bytes += ParLen;
        end else begin
          // noise between frames; may open or break a frame
          push_byte(8'($urandom_range(0, 255)));
          frame_bytes += 1;
        end
      end
    end

    // Wait out the feed, the pending frames and the pipeline tail
    @(posedge clk_i);
    while (feed_q.size() != 0 || holding) @(posedge clk_i);
    while (frames_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("[serial_command_frame_parser_core] OK");
    end else begin
      $display("[serial_command_frame_parser_core] ERROR");
    end
    $finish;
  end

endmodule
